// ===== sv/multi_client_timeout_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// multi_client_timeout_scheduler assertion macros
// checks are clocked on clock and held off while reset is high
// ----------------------------------------------------------------------------
`ifndef MULTI_CLIENT_TIMEOUT_SCHEDULER_ASSERT_SVH
`define MULTI_CLIENT_TIMEOUT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MCTS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCTS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_pkg
// shared types and constants of the multi-client timeout scheduler
// ----------------------------------------------------------------------------
package mcts_pkg;

   localparam int NUM_CLIENTS = 6;
   localparam int SLOT_IDX_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int MASK_W      = 6;

   localparam logic [31:0] NS_SCALE     = 32'd1000000;
   localparam logic [31:0] PERIOD_RESET = 32'd69841279;

   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [1:0] CMD_READ = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_IRQ  = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  client;
      logic [63:0] delay_ns;
      logic [63:0] counter_ticks;
   } req_type;

   typedef struct packed {
      logic [63:0]       time_ns;
      logic [MASK_W-1:0] expired_mask;
      logic              comparator_write;
      logic [63:0]       comparator_ticks;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                  start;
      logic                  set_en;
      logic [SLOT_IDX_W-1:0] set_idx;
      logic [63:0]           set_value;
      logic [63:0]           now;
   } scan_req_type;

   typedef struct packed {
      logic              done;
      logic [MASK_W-1:0] mask;
      logic [63:0]       earliest;
   } scan_rsp_type;

endpackage

// ===== sv/mcts_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_mul
// shared 32x32 multiplier with registered 64-bit product
// ----------------------------------------------------------------------------
module mcts_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in  = 64'(mul_a) * 64'(mul_b);
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== sv/mcts_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_div
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// ----------------------------------------------------------------------------
module mcts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mcts_pkg::div_req_type div_req,
   output mcts_pkg::div_rsp_type div_rsp
);
   import mcts_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [63:0]          quo_ff, quo_in;
   logic [31:0]          divisor_ff, divisor_in;
   logic [32:0]          shifted;
   logic [32:0]          diff;
   logic                 ge;

   // a zero divisor makes every step succeed, so the quotient saturates to all ones
   assign shifted = {rem_ff, quo_ff[63]};
   assign ge      = shifted >= {1'b0, divisor_ff};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== sv/mcts_slots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_slots
// client deadline store with a one-slot-per-cycle expiry and minimum scan
// ----------------------------------------------------------------------------
module mcts_slots (
   input  logic                   clock,
   input  logic                   reset,
   input  mcts_pkg::scan_req_type scan_req,
   output mcts_pkg::scan_rsp_type scan_rsp
);
   import mcts_pkg::*;

   typedef enum logic {
      SL_IDLE,
      SL_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [63:0]           store_ff [NUM_CLIENTS];
   logic [63:0]           store_in [NUM_CLIENTS];
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [63:0]           earliest_ff, earliest_in;
   logic [63:0]           now_ff, now_in;
   logic                  done_ff, done_in;
   logic [63:0]           cur;

   assign cur = store_ff[idx_ff];

   always_comb begin
      state_in    = state_ff;
      store_in    = store_ff;
      idx_in      = idx_ff;
      mask_in     = mask_ff;
      earliest_in = earliest_ff;
      now_in      = now_ff;
      done_in     = 1'b0;
      case (state_ff)
         SL_IDLE: begin
            if (scan_req.start) begin
               if (scan_req.set_en) begin
                  store_in[scan_req.set_idx] = scan_req.set_value;
               end
               now_in      = scan_req.now;
               idx_in      = '0;
               mask_in     = '0;
               earliest_in = '1;
               state_in    = SL_SCAN;
            end
         end
         SL_SCAN: begin
            if (cur <= now_ff) begin
               // slots past the mask width shift out of the mask
               mask_in          = mask_ff | (MASK_W'(1) << idx_ff);
               store_in[idx_ff] = '1;
            end else if (cur < earliest_ff) begin
               earliest_in = cur;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_IDX_W'(NUM_CLIENTS - 1)) begin
               done_in  = 1'b1;
               state_in = SL_IDLE;
            end
         end
         default: begin
            state_in = SL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      earliest_ff <= earliest_in;
      now_ff      <= now_in;
      if (reset) begin
         state_ff <= SL_IDLE;
         done_ff  <= 1'b0;
         for (int k = 0; k < NUM_CLIENTS; k++) begin
            store_ff[k] <= '1;
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         store_ff <= store_in;
      end
   end

   assign scan_rsp.done     = done_ff;
   assign scan_rsp.mask     = mask_ff;
   assign scan_rsp.earliest = earliest_ff;

endmodule

// ===== sv/multi_client_timeout_scheduler.sv =====
`timescale 1ns / 1ps
`include "multi_client_timeout_scheduler_assert.svh"
// ----------------------------------------------------------------------------
// multi_client_timeout_scheduler
// per-client deadline timer that expires due clients and reprograms the
// comparator for the earliest pending deadline
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_data (mcts_pkg::req_type)
//   rsp       out        rsp_valid/rsp_stall  rsp_data (mcts_pkg::rsp_type)
//   csr       in         csr_write_enable     csr_write_data (tick period, fs)
//
// one request at a time; each tick/ns conversion is two passes through the
// shared 32x32 multiplier and 64 steps of the bit-serial divider
// the response is registered after the tick-to-ns conversion for read time,
// after it and the slot scan for set or interrupt, and after a second
// conversion to ticks when the comparator is rewritten; req_stall drops
// as the response is registered; synchronous reset empties every client slot
// a new request is taken while the previous response waits under rsp_stall
// ----------------------------------------------------------------------------
module multi_client_timeout_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcts_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);
   import mcts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_DIV_WAIT,
      ST_SCAN_WAIT,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       period_ff, period_in;
   logic              phase_ff, phase_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       now_ff, now_in;
   logic [63:0]       earliest_ff, earliest_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              wr_ff, wr_in;
   logic [63:0]       cmp_ff, cmp_in;

   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_prod;
   logic [63:0]  mul_src;
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   scan_req_type scan_req;
   scan_rsp_type scan_rsp;
   logic         processing;

   mcts_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   mcts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mcts_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   // phase 0 converts ticks to ns, phase 1 converts the earliest deadline to ticks
   assign mul_src = phase_ff ? earliest_ff : req_ff.counter_ticks;
   assign mul_a   = (state_ff == ST_MUL_HI) ? mul_src[63:32] : mul_src[31:0];
   assign mul_b   = phase_ff ? NS_SCALE : period_ff;

   assign processing = (req_ff.cmd == CMD_SET) || (req_ff.cmd == CMD_IRQ);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      period_in    = csr_write_enable ? csr_write_data : period_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      now_in       = now_ff;
      earliest_in  = earliest_ff;
      mask_in      = mask_ff;
      wr_in        = wr_ff;
      cmp_in       = cmp_ff;

      // upper partial product only contributes its low half after the shift
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff + {mul_prod[31:0], 32'h0};
      div_req.divisor  = phase_ff ? period_ff : NS_SCALE;

      scan_req.start     = 1'b0;
      scan_req.set_en    = (req_ff.cmd == CMD_SET) && (32'(req_ff.client) < NUM_CLIENTS);
      scan_req.set_idx   = SLOT_IDX_W'(req_ff.client);
      scan_req.set_value = div_rsp.quotient + req_ff.delay_ns;
      scan_req.now       = div_rsp.quotient;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               phase_in = 1'b0;
               mask_in  = '0;
               wr_in    = 1'b0;
               cmp_in   = '0;
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = mul_prod;
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (phase_ff) begin
                  cmp_in   = div_rsp.quotient;
                  state_in = ST_DONE;
               end else begin
                  now_in = div_rsp.quotient;
                  if (processing) begin
                     scan_req.start = 1'b1;
                     state_in       = ST_SCAN_WAIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_SCAN_WAIT: begin
            if (scan_rsp.done) begin
               mask_in = scan_rsp.mask;
               if (scan_rsp.earliest != '1) begin
                  wr_in       = 1'b1;
                  earliest_in = scan_rsp.earliest;
                  phase_in    = 1'b1;
                  state_in    = ST_MUL_LO;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.time_ns          = now_ff;
               rsp_in.expired_mask     = mask_ff;
               rsp_in.comparator_write = wr_ff;
               rsp_in.comparator_ticks = cmp_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      phase_ff    <= phase_in;
      acc_ff      <= acc_in;
      now_ff      <= now_in;
      earliest_ff <= earliest_in;
      mask_ff     <= mask_in;
      wr_ff       <= wr_in;
      cmp_ff      <= cmp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MCTS_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "scheduler took a request without going busy")
   `MCTS_ASSERT_IMP(a_div_done_expected, div_rsp.done, state_ff == ST_DIV_WAIT,
      "divider finished while the sequencer was not waiting for it")
   `MCTS_ASSERT_IMP(a_scan_done_expected, scan_rsp.done, state_ff == ST_SCAN_WAIT,
      "slot scan finished while the sequencer was not waiting for it")
   `MCTS_ASSERT_IMP(a_cmp_zero_without_write, rsp_valid && !rsp_data.comparator_write,
      rsp_data.comparator_ticks == 64'h0,
      "comparator value set on a response without a comparator write")

endmodule

// ===== tb/multi_client_timeout_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_client_timeout_scheduler_tb
// Drives set, interrupt, read-time and spare requests through the scheduler under
// several tick periods and random idling. A scoreboard keeps its own copy of
// the client deadlines and predicts the time, the expiry mask and the
// comparator write of every response.
// ----------------------------------------------------------------------------
module multi_client_timeout_scheduler_tb;
   import mcts_pkg::*;

   localparam logic [1:0] CMD_SPARE  = 2'd3;
   localparam int         CYCLE_LIMIT = 1500000;

   class deadline_scoreboard;
      logic [63:0] period_fs;
      logic [63:0] deadline [NUM_CLIENTS];
      rsp_type     expected_rsp_q [$];
      int          errors;
      int          requests;
      int          checked;
      int          expiries;
      int          cmp_writes;

      function new();
         period_fs = {32'd0, PERIOD_RESET};
         foreach (deadline[k]) deadline[k] = '1;
      endfunction

      function void set_period(input logic [31:0] value);
         period_fs = {32'd0, value};
      endfunction

      function logic [63:0] to_ns(input logic [63:0] ticks);
         logic [63:0] product;
         product = ticks * period_fs;
         return product / 64'd1000000;
      endfunction

      function logic [63:0] to_ticks(input logic [63:0] ns);
         logic [63:0] scaled;
         if (period_fs == 0) return '1;
         scaled = ns * 64'd1000000;
         return scaled / period_fs;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void note_request(input req_type r);
         rsp_type     e;
         logic [63:0] now;
         logic [63:0] earliest;
         int          k;
         e = '0;
         now = to_ns(r.counter_ticks);
         e.time_ns = now;
         requests++;
         if (r.cmd == CMD_SET || r.cmd == CMD_IRQ) begin
            earliest = '1;
            if (r.cmd == CMD_SET && r.client < NUM_CLIENTS)
               deadline[r.client] = now + r.delay_ns;
            for (k = 0; k < NUM_CLIENTS; k++) begin
               if (deadline[k] <= now) begin
                  if (k < MASK_W) e.expired_mask[k] = 1'b1;
                  deadline[k] = '1;
               end else if (deadline[k] < earliest) begin
                  earliest = deadline[k];
               end
            end
            if (earliest != '1) begin
               e.comparator_write = 1'b1;
               e.comparator_ticks = to_ticks(earliest);
            end
         end
         expected_rsp_q.push_back(e);
      endfunction

      function void compare_field(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
         if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(input rsp_type a);
         rsp_type e;
         if (expected_rsp_q.size() == 0) begin
            $error("response with no request outstanding, time_ns %0h", a.time_ns);
            errors++;
            return;
         end
         e = expected_rsp_q.pop_front();
         checked++;
         expiries += $countones(e.expired_mask);
         if (e.comparator_write) cmp_writes++;
         compare_field("time_ns", e.time_ns, a.time_ns);
         compare_field("expired_mask", 64'(e.expired_mask), 64'(a.expired_mask));
         compare_field("comparator_write", 64'(e.comparator_write),
                       64'(a.comparator_write));
         compare_field("comparator_ticks", e.comparator_ticks, a.comparator_ticks);
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_data         = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data   = '0;

   deadline_scoreboard sb = new();
   bit idle_on = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;
   int periods_used = 1;

   multi_client_timeout_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("multi_client_timeout_scheduler_tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure in short bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   function automatic req_type make_req(input logic [1:0] cmd, input logic [2:0] client,
                                        input logic [63:0] delay,
                                        input logic [63:0] ticks);
      req_type r;
      r.cmd           = cmd;
      r.client        = client;
      r.delay_ns      = delay;
      r.counter_ticks = ticks;
      return r;
   endfunction

   // valid stays high between back-to-back requests, dropped only for a gap
   task automatic send_req(input req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_period(value);
      periods_used++;
   endtask

   task automatic run_phase(input logic [31:0] period, input int count, input bit quiet);
      logic [63:0] step_ticks;
      logic [63:0] step_ns;
      logic [63:0] dmax;
      logic [63:0] ticks;
      logic [63:0] delay;
      logic [1:0]  cmd;
      logic [2:0]  client;
      int          i;
      int          pick;
      write_period(period);
      step_ticks = (period == 0) ? 64'd100 : 64'd2000000000 / period + 1;
      step_ns = sb.to_ns(step_ticks);
      if (step_ns == 0) step_ns = 1;
      dmax = step_ns * 6;
      if (dmax > 64'hFFFF_FFFF) dmax = 64'hFFFF_FFFF;
      ticks = {32'd0, $urandom()};
      for (i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_on = !quiet && ($urandom_range(0, 3) != 0);
         if (!quiet && $urandom_range(0, 99) == 0) wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_req(make_req(2'($urandom()), 3'($urandom()), {$urandom(), $urandom()},
                              {$urandom(), $urandom()}));
         end else begin
            ticks += ({32'd0, $urandom_range(0, 300)} * step_ticks) / 100;
            pick = $urandom_range(0, 99);
            cmd = (pick < 50) ? CMD_SET : (pick < 85) ? CMD_IRQ :
                  (pick < 95) ? CMD_READ : CMD_SPARE;
            client = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 19) == 0) delay = {$urandom(), $urandom()};
            else delay = {32'd0, $urandom_range(0, 32'(dmax))};
            send_req(make_req(cmd, client, delay, ticks));
         end
      end
      wait_idle();
   endtask

   initial begin
      logic [63:0] now_ns;
      int          k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset period
      send_req(make_req(CMD_READ, 3'd0, 64'd0, 64'd0));
      send_req(make_req(CMD_READ, 3'd7, '1, '1));
      send_req(make_req(CMD_SPARE, 3'd2, 64'd77, 64'd1000));
      send_req(make_req(CMD_SET, 3'd0, 64'd5000, 64'd1000));
      // zero delay expires at once
      send_req(make_req(CMD_SET, 3'd5, 64'd0, 64'd1000));
      // clients past the last slot write nothing
      send_req(make_req(CMD_SET, 3'd6, 64'd10, 64'd1000));
      send_req(make_req(CMD_SET, 3'd7, 64'd10, 64'd1000));
      send_req(make_req(CMD_IRQ, 3'd0, 64'd0, 64'd1000));
      send_req(make_req(CMD_IRQ, 3'd0, 64'd0, 64'd1100));
      send_req(make_req(CMD_IRQ, 3'd0, 64'd0, 64'd1200));
      // deadline landing exactly on all ones reads as empty
      now_ns = sb.to_ns(64'd2000);
      send_req(make_req(CMD_SET, 3'd1, '1 - now_ns, 64'd2000));
      // wrapping delay puts the deadline just behind now
      send_req(make_req(CMD_SET, 3'd2, '1, 64'd2000));
      for (k = 0; k < NUM_CLIENTS; k++)
         send_req(make_req(CMD_SET, 3'(k), 64'(100 * (k + 1)), 64'd3000));
      send_req(make_req(CMD_IRQ, 3'd0, 64'd0, 64'd4000));
      send_req(make_req(CMD_SET, 3'd4, 64'd0, 64'd0));
      send_req(make_req(CMD_SET, 3'd3, 64'hFFFF_0000_0000_0000, 64'd5000));
      send_req(make_req(CMD_IRQ, 3'd5, '1, '1));
      wait_idle();

      run_phase(32'd1, 300, 1'b0);
      run_phase(32'hFFFF_FFFF, 300, 1'b0);
      run_phase(32'd0, 60, 1'b0);
      run_phase($urandom_range(2, 32'hFFFF_FFFE), 330, 1'b0);
      run_phase($urandom_range(2, 100000), 300, 1'b0);
      run_phase(PERIOD_RESET, 340, 1'b1);

      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("%0d requests over %0d tick periods, %0d responses checked",
               sb.requests, periods_used, sb.checked);
      $display("%0d client expiries and %0d comparator writes predicted",
               sb.expiries, sb.cmp_writes);
      if (sb.errors == 0) begin
         $display("multi_client_timeout_scheduler_tb OK");
      end else begin
         $display("multi_client_timeout_scheduler_tb NOT OK");
      end
      $finish;
   end

endmodule
